### rtl/json_string_unescaper_assert.svh
// ----------------------------------------------------------------------------
// json_string_unescaper_assert.svh
// assertion macros used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, disabled while reset is low
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int LENGTH_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH         = 4;
    localparam int FIELD_LEN_W         = 24;

    localparam logic [FIELD_LEN_W-1:0] MAX_BYTES_RESET = 24'hFF_FFFF;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_UNTERMINATED = 4'd1,
        ST_CONTROL      = 4'd2,
        ST_TOO_LONG     = 4'd3,
        ST_END_IN_ESC   = 4'd4,
        ST_UNKNOWN_ESC  = 4'd5,
        ST_BAD_HEX      = 4'd6,
        ST_LONE_HIGH    = 4'd7,
        ST_BAD_PAIR     = 4'd8,
        ST_LONE_LOW     = 4'd9,
        ST_BAD_UTF8     = 4'd10
    } t_status;

    // one queue entry: either up to four decoded bytes or one status
    typedef struct packed {
        logic                   is_status;
        t_status                status;
        logic [FIELD_LEN_W-1:0] length;
        logic [1:0]             count_m1;
        logic [3:0][7:0]        bytes;
    } t_bundle;

endpackage

### rtl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// valid/ready channels of the json string unescaper
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       start_req;
    logic [7:0] in_byte;

    modport source (output valid, output mode, output start_req, output in_byte,
                    input ready);
    modport sink   (input valid, input mode, input start_req, input in_byte,
                    output ready);
endinterface

interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [3:0]  status;
    logic [23:0] length;
    logic        last;

    modport source (output valid, output kind, output data_byte, output status,
                    output length, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input length, input last, output ready);
endinterface

interface jsu_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] byte_limit;

    modport source (output valid, output byte_limit, input ready);
    modport sink   (input valid, input byte_limit, output ready);
endinterface

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// accepts document bytes, runs the escape decoder and pushes result bundles
// ----------------------------------------------------------------------------
module jsu_front #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jsu_in_if.sink           i_in,
    jsu_cfg_if.sink          i_cfg,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output jsu_pkg::t_bundle o_push_data
);
    import jsu_pkg::*;

    localparam int LIM_W = 33;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_AFTER_HIGH,
        PH_AFTER_HIGH_ESC,
        PH_LOWHEX
    } t_phase;

    typedef struct packed {
        logic [1:0]  pend;
        logic [20:0] part;
        logic [1:0]  seq;
        logic        bad;
    } t_utf8;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      n_m1;
    } t_enc;

    localparam t_utf8 U_CLEAR = '{pend: 2'd0, part: 21'd0, seq: 2'd0, bad: 1'b0};

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic t_enc encode(logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.n_m1     = 2'd0;
        end else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.n_m1     = 2'd1;
        end else if (cp < 21'h10000) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.n_m1     = 2'd2;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.n_m1     = 2'd3;
        end
        return e;
    endfunction

    function automatic t_utf8 utf8_feed(t_utf8 s, logic [7:0] b);
        t_utf8       r;
        logic [20:0] lo;
        r  = s;
        lo = '0;
        if (!s.bad) begin
            if (s.pend == 2'd0) begin
                if (b[7]) begin
                    if (b[7:5] == 3'b110) begin
                        r.seq  = 2'd1;
                        r.part = {16'd0, b[4:0]};
                        r.pend = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        r.seq  = 2'd2;
                        r.part = {17'd0, b[3:0]};
                        r.pend = 2'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        r.seq  = 2'd3;
                        r.part = {18'd0, b[2:0]};
                        r.pend = 2'd3;
                    end else begin
                        r.bad = 1'b1;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                r.bad = 1'b1;
            end else begin
                r.part = {s.part[14:0], b[5:0]};
                r.pend = s.pend - 2'd1;
                if (r.pend == 2'd0) begin
                    lo = (s.seq == 2'd1) ? 21'h80 : ((s.seq == 2'd2) ? 21'h800 : 21'h10000);
                    if (r.part < lo || r.part > 21'h10FFFF ||
                        (r.part >= 21'hD800 && r.part <= 21'hDFFF)) begin
                        r.bad = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    t_phase                 r_phase, n_phase, b_phase;
    logic [15:0]            r_hex, n_hex, b_hex;
    logic [1:0]             r_hex_cnt, n_hex_cnt, b_hex_cnt;
    logic [9:0]             r_high, n_high, b_high;
    logic [LENGTH_BITS-1:0] r_len, n_len, b_len;
    t_utf8                  r_u, n_u, b_u;
    logic [FIELD_LEN_W-1:0] r_max_bytes;

    logic        accept;
    logic        want_cp, want_raw, fail, close_ok;
    t_status     fail_code;
    logic [20:0] cp;
    logic [7:0]  raw;
    logic [4:0]  digit;
    logic [15:0] acc;
    t_enc        enc;
    logic [LIM_W-1:0] cap, max_ext, lim, next_len, len_ext;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = i_push_ready;
    assign i_cfg.ready = 1'b1;

    assign cap     = (LIM_W'(1) << LENGTH_BITS) - LIM_W'(1);
    assign max_ext = LIM_W'(r_max_bytes);
    assign lim     = (max_ext > cap) ? cap : max_ext;

    always_comb begin
        b_phase   = r_phase;
        b_hex     = r_hex;
        b_hex_cnt = r_hex_cnt;
        b_high    = r_high;
        b_len     = r_len;
        b_u       = r_u;
        if (i_in.start_req) begin
            b_phase   = PH_BODY;
            b_hex     = '0;
            b_hex_cnt = '0;
            b_high    = '0;
            b_len     = '0;
            b_u       = U_CLEAR;
        end
        n_phase   = b_phase;
        n_hex     = b_hex;
        n_hex_cnt = b_hex_cnt;
        n_high    = b_high;
        n_len     = b_len;
        n_u       = b_u;
        want_cp   = 1'b0;
        want_raw  = 1'b0;
        fail      = 1'b0;
        close_ok  = 1'b0;
        fail_code = ST_OK;
        cp        = '0;
        raw       = i_in.in_byte;
        digit     = hex_val(i_in.in_byte);
        acc       = {b_hex[11:0], digit[3:0]};

        if (i_in.mode) begin
            case (b_phase)
                PH_BODY: begin
                    fail = 1'b1; fail_code = ST_UNTERMINATED;
                end
                PH_ESC: begin
                    fail = 1'b1; fail_code = ST_END_IN_ESC;
                end
                PH_HEX, PH_LOWHEX: begin
                    fail = 1'b1; fail_code = ST_BAD_HEX;
                end
                PH_AFTER_HIGH, PH_AFTER_HIGH_ESC: begin
                    fail = 1'b1; fail_code = ST_LONE_HIGH;
                end
                default: begin
                end
            endcase
        end else begin
            case (b_phase)
                PH_BODY: begin
                    if (i_in.in_byte == CH_QUOTE) begin
                        if (b_u.bad || b_u.pend != 2'd0) begin
                            fail = 1'b1; fail_code = ST_BAD_UTF8;
                        end else begin
                            close_ok = 1'b1;
                        end
                    end else if (i_in.in_byte < CH_SPACE) begin
                        fail = 1'b1; fail_code = ST_CONTROL;
                    end else if (i_in.in_byte == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else begin
                        want_raw = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase  = PH_BODY;
                    want_raw = 1'b1;
                    case (i_in.in_byte)
                        CH_B: raw = 8'h08;
                        CH_F: raw = 8'h0C;
                        CH_N: raw = 8'h0A;
                        CH_R: raw = 8'h0D;
                        CH_T: raw = 8'h09;
                        CH_QUOTE, CH_BSL, CH_SLASH: raw = i_in.in_byte;
                        CH_U: begin
                            want_raw  = 1'b0;
                            n_phase   = PH_HEX;
                            n_hex     = '0;
                            n_hex_cnt = '0;
                        end
                        default: begin
                            want_raw = 1'b0;
                            fail = 1'b1; fail_code = ST_UNKNOWN_ESC;
                        end
                    endcase
                end
                PH_HEX, PH_LOWHEX: begin
                    if (digit[4]) begin
                        fail = 1'b1; fail_code = ST_BAD_HEX;
                    end else begin
                        n_hex = acc;
                        if (b_hex_cnt != 2'd3) begin
                            n_hex_cnt = b_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = '0;
                            if (b_phase == PH_LOWHEX) begin
                                if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                                    fail = 1'b1; fail_code = ST_BAD_PAIR;
                                end else begin
                                    n_phase = PH_BODY;
                                    want_cp = 1'b1;
                                    cp      = 21'h10000 + {1'b0, b_high, acc[9:0]};
                                end
                            end else if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                                n_high  = acc[9:0];
                                n_phase = PH_AFTER_HIGH;
                            end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                                fail = 1'b1; fail_code = ST_LONE_LOW;
                            end else begin
                                n_phase = PH_BODY;
                                want_cp = 1'b1;
                                cp      = {5'd0, acc};
                            end
                        end
                    end
                end
                PH_AFTER_HIGH: begin
                    if (i_in.in_byte == CH_BSL) begin
                        n_phase = PH_AFTER_HIGH_ESC;
                    end else begin
                        fail = 1'b1; fail_code = ST_LONE_HIGH;
                    end
                end
                PH_AFTER_HIGH_ESC: begin
                    if (i_in.in_byte == CH_U) begin
                        n_phase   = PH_LOWHEX;
                        n_hex     = '0;
                        n_hex_cnt = '0;
                    end else begin
                        fail = 1'b1; fail_code = ST_LONE_HIGH;
                    end
                end
                default: begin
                end
            endcase
        end

        // raw and short-escape bytes pass as one byte, code points get encoded
        if (want_raw) begin
            enc          = '0;
            enc.bytes[0] = raw;
        end else begin
            enc = encode(cp);
        end
        next_len = LIM_W'(b_len) + LIM_W'(enc.n_m1) + LIM_W'(1);

        if (want_raw || want_cp) begin
            if (next_len > lim) begin
                fail = 1'b1; fail_code = ST_TOO_LONG;
            end else begin
                n_len = next_len[LENGTH_BITS-1:0];
                for (int i = 0; i < 4; i++) begin
                    if (2'(i) <= enc.n_m1) begin
                        n_u = utf8_feed(n_u, enc.bytes[i]);
                    end
                end
            end
        end

        if (fail || close_ok || b_phase == PH_IDLE) begin
            n_phase   = PH_IDLE;
            n_hex     = '0;
            n_hex_cnt = '0;
            n_high    = '0;
            n_len     = '0;
            n_u       = U_CLEAR;
        end

        len_ext                = LIM_W'(b_len);
        o_push_data.is_status  = fail || close_ok;
        o_push_data.status     = fail ? fail_code : ST_OK;
        o_push_data.length     = close_ok ? len_ext[FIELD_LEN_W-1:0] : '0;
        o_push_data.count_m1   = enc.n_m1;
        o_push_data.bytes      = enc.bytes;
        o_push_valid           = i_in.valid && (fail || close_ok || want_raw || want_cp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hex       <= '0;
            r_hex_cnt   <= '0;
            r_high      <= '0;
            r_len       <= '0;
            r_u         <= U_CLEAR;
            r_max_bytes <= MAX_BYTES_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_max_bytes <= i_cfg.byte_limit;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_hex     <= n_hex;
                r_hex_cnt <= n_hex_cnt;
                r_high    <= n_high;
                r_len     <= n_len;
                r_u       <= n_u;
            end
        end
    end

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// short first-in first-out queue of result bundles between front and back
// ----------------------------------------------------------------------------
module jsu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  jsu_pkg::t_bundle i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output jsu_pkg::t_bundle o_pop_data
);
    import jsu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// splits queued bundles into single results behind an output register
// ----------------------------------------------------------------------------
module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  jsu_pkg::t_bundle i_q_data,
    jsu_out_if.source        o_out
);
    import jsu_pkg::*;

    logic [1:0]  r_idx;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_data;
    logic [3:0]  r_status;
    logic [23:0] r_length;
    logic        r_last;
    logic        load, is_last;

    assign load      = i_q_valid && (!r_valid || o_out.ready);
    assign is_last   = i_q_data.is_status || (r_idx == i_q_data.count_m1);
    assign o_q_ready = load && is_last;

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_kind;
    assign o_out.data_byte = r_data;
    assign o_out.status    = r_status;
    assign o_out.length    = r_length;
    assign o_out.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_q_data.is_status;
            r_data   <= i_q_data.is_status ? 8'd0 : i_q_data.bytes[r_idx];
            r_status <= i_q_data.is_status ? i_q_data.status : ST_OK;
            r_length <= i_q_data.is_status ? i_q_data.length : 24'd0;
            r_last   <= is_last;
        end
    end

endmodule

### rtl/json_string_unescaper.sv
// ----------------------------------------------------------------------------
// json_string_unescaper
// json string body decoder with utf-8 re-encoding of unicode escapes
// ----------------------------------------------------------------------------
// One document byte is accepted per cycle. Each accepted byte is decoded in
// the cycle it is taken and its results (up to four decoded bytes, or one
// status) go as a bundle into a four-entry queue; the output stage sends one
// result per cycle while the output is ready, and the queue absorbs bursts of
// multi-byte escapes. Input ready drops only while the queue is full. The
// first result of a byte passes through the queue and then the output
// register before it reaches the output. The limit register is written
// through the config channel, which is always ready; write it only while
// the block is idle.
module json_string_unescaper #(
    parameter int LENGTH_BITS = jsu_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_cfg_if.sink   i_cfg,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    logic    push_valid, push_ready, pop_valid, pop_ready;
    t_bundle push_data, pop_data;

    jsu_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    jsu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .o_q_ready (pop_ready),
        .i_q_data  (pop_data),
        .o_out     (o_out)
    );

endmodule

### rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks on the result channel of the unescaper
// ----------------------------------------------------------------------------
`include "json_string_unescaper_assert.svh"

module jsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_kind,
    input logic [3:0]  i_status,
    input logic [23:0] i_length,
    input logic        i_last
);
    import jsu_pkg::*;

    // a pending transaction is not withdrawn
    `JSU_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, i_valid && !i_ready, i_valid)

    // a status always closes the results of its byte
    `JSU_ASSERT_NOW(a_status_is_last, i_clk, i_rst_n, i_valid && i_kind, i_last)

    // error status carries no length
    `JSU_ASSERT_NOW(a_error_no_length, i_clk, i_rst_n,
        i_valid && i_kind && (i_status != ST_OK), i_length == 24'd0)

    // decoded bytes carry neither status nor length
    `JSU_ASSERT_NOW(a_byte_clean, i_clk, i_rst_n, i_valid && !i_kind,
        (i_status == ST_OK) && (i_length == 24'd0))

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_kind   (o_out.kind),
    .i_status (o_out.status),
    .i_length (o_out.length),
    .i_last   (o_out.last)
);

### sim/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_scoreboard
// watches the json string unescaper channels, predicts and compares results
// ----------------------------------------------------------------------------
// Every accepted input transaction runs through a decoder model kept here. The
// model holds its own copy of the decoder state and of the length limit. The
// decoded bytes and status results that it predicts wait in a queue. Every
// accepted output transaction is compared with the oldest entry of that queue.
// The mismatch count and the number of outstanding results go to the top.
// ----------------------------------------------------------------------------
module jsu_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    jsu_in_if    i_in_mon,
    jsu_out_if   i_out_mon,
    jsu_cfg_if   i_cfg_mon,
    output int   o_mismatches,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_BODY,
        DEC_ESCAPE,
        DEC_HEX,
        DEC_WAIT_BSLASH,
        DEC_WAIT_U,
        DEC_LOW_HEX
    } t_dec_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        t_status     status;
        logic [23:0] length;
        logic        last;
    } t_result;

    // decoder model state
    t_dec_phase  dec_phase;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  high_bits;
    logic [23:0] out_len;
    logic [1:0]  u8_pending;
    logic [20:0] u8_partial;
    logic [1:0]  u8_seq_len;
    logic        u8_bad;
    logic [23:0] max_bytes;

    t_result item_results[$];
    t_result decoder_results[$];
    int      mismatches;

    function automatic void clear_decoder();
        dec_phase  = DEC_IDLE;
        hex_acc    = '0;
        hex_cnt    = '0;
        high_bits  = '0;
        out_len    = '0;
        u8_pending = '0;
        u8_partial = '0;
        u8_seq_len = '0;
        u8_bad     = 1'b0;
    endfunction

    function automatic void push_result(input logic kind, input logic [7:0] data,
                                        input t_status st, input logic [23:0] len);
        t_result r;
        r.kind   = kind;
        r.data   = data;
        r.status = st;
        r.length = len;
        r.last   = 1'b0;
        item_results.insert(item_results.size(), r);
    endfunction

    // an error drops everything of this transaction and leaves only the status
    function automatic void raise_error(input t_status st);
        clear_decoder();
        item_results.delete();
        push_result(1'b1, 8'h00, st, '0);
    endfunction

    // sticky utf-8 validity of the decoded stream
    function automatic void track_utf8(input logic [7:0] b);
        logic [20:0] min_cp;
        if (u8_bad)
            return;
        if (u8_pending == 2'd0) begin
            if (b < 8'h80)
                return;
            if ((b & 8'hE0) == 8'hC0) begin
                u8_seq_len = 2'd1;
                u8_partial = {16'd0, b[4:0]};
            end else if ((b & 8'hF0) == 8'hE0) begin
                u8_seq_len = 2'd2;
                u8_partial = {17'd0, b[3:0]};
            end else if ((b & 8'hF8) == 8'hF0) begin
                u8_seq_len = 2'd3;
                u8_partial = {18'd0, b[2:0]};
            end else begin
                u8_bad = 1'b1;
                return;
            end
            u8_pending = u8_seq_len;
            return;
        end
        if ((b & 8'hC0) != 8'h80) begin
            u8_bad = 1'b1;
            return;
        end
        u8_partial = {u8_partial[14:0], b[5:0]};
        u8_pending = u8_pending - 2'd1;
        if (u8_pending == 2'd0) begin
            min_cp = (u8_seq_len == 2'd1) ? 21'h80 :
                     (u8_seq_len == 2'd2) ? 21'h800 : 21'h10000;
            if (u8_partial < min_cp || u8_partial > 21'h10FFFF ||
                (u8_partial >= 21'hD800 && u8_partial <= 21'hDFFF))
                u8_bad = 1'b1;
        end
    endfunction

    function automatic void append_bytes(input logic [3:0][7:0] b, input int n);
        logic [24:0] next_len;
        next_len = {1'b0, out_len} + 25'(n);
        if (next_len > {1'b0, max_bytes}) begin
            raise_error(ST_TOO_LONG);
            return;
        end
        out_len = next_len[23:0];
        for (int i = 0; i < n; i++) begin
            track_utf8(b[i]);
            push_result(1'b0, b[i], ST_OK, '0);
        end
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        logic [3:0][7:0] b;
        b = '0;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
            append_bytes(b, 1);
        end else if (cp < 21'h800) begin
            b[0] = {3'b110, cp[10:6]};
            b[1] = {2'b10, cp[5:0]};
            append_bytes(b, 2);
        end else if (cp < 21'h10000) begin
            b[0] = {4'b1110, cp[15:12]};
            b[1] = {2'b10, cp[11:6]};
            b[2] = {2'b10, cp[5:0]};
            append_bytes(b, 3);
        end else begin
            b[0] = {5'b11110, cp[20:18]};
            b[1] = {2'b10, cp[17:12]};
            b[2] = {2'b10, cp[11:6]};
            b[3] = {2'b10, cp[5:0]};
            append_bytes(b, 4);
        end
    endfunction

    function automatic int nibble_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'(8'h30);
        if (c >= "a" && c <= "f")
            return int'(c) - int'(8'h61) + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'(8'h41) + 10;
        return -1;
    endfunction

    function automatic void escape_letter(input logic [7:0] c);
        logic [3:0][7:0] b;
        b = '0;
        case (c)
            CH_B:                         b[0] = 8'h08;
            CH_F:                         b[0] = 8'h0C;
            CH_N:                         b[0] = 8'h0A;
            CH_R:                         b[0] = 8'h0D;
            CH_T:                         b[0] = 8'h09;
            CH_QUOTE, CH_BSLASH, CH_SLASH: b[0] = c;
            CH_U: begin
                dec_phase = DEC_HEX;
                hex_acc   = '0;
                hex_cnt   = '0;
                return;
            end
            default: begin
                raise_error(ST_UNKNOWN_ESC);
                return;
            end
        endcase
        dec_phase = DEC_BODY;
        append_bytes(b, 1);
    endfunction

    function automatic void body_byte(input logic [7:0] c);
        logic [3:0][7:0] b;
        logic [23:0]     len;
        b = '0;
        if (c == CH_QUOTE) begin
            if (u8_bad || u8_pending != 2'd0) begin
                raise_error(ST_BAD_UTF8);
                return;
            end
            len = out_len;
            clear_decoder();
            push_result(1'b1, 8'h00, ST_OK, len);
            return;
        end
        if (c < 8'h20) begin
            raise_error(ST_CONTROL);
            return;
        end
        if (c == CH_BSLASH) begin
            dec_phase = DEC_ESCAPE;
            return;
        end
        b[0] = c;
        append_bytes(b, 1);
    endfunction

    function automatic void hex_byte(input logic [7:0] c, input logic low_half);
        int d;
        d = nibble_value(c);
        if (d < 0) begin
            raise_error(ST_BAD_HEX);
            return;
        end
        hex_acc = {hex_acc[11:0], 4'(d)};
        if (hex_cnt < 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
            return;
        end
        hex_cnt = '0;
        if (low_half) begin
            if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                raise_error(ST_BAD_PAIR);
                return;
            end
            dec_phase = DEC_BODY;
            emit_code_point(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
            return;
        end
        if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
            high_bits = hex_acc[9:0];
            dec_phase = DEC_WAIT_BSLASH;
            return;
        end
        if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
            raise_error(ST_LONE_LOW);
            return;
        end
        dec_phase = DEC_BODY;
        emit_code_point({5'd0, hex_acc});
    endfunction

    function automatic void decode_item(input logic mode, input logic start,
                                        input logic [7:0] c);
        t_result r;
        item_results.delete();
        if (start) begin
            clear_decoder();
            dec_phase = DEC_BODY;
        end
        if (mode) begin
            case (dec_phase)
                DEC_BODY:                    raise_error(ST_UNTERMINATED);
                DEC_ESCAPE:                  raise_error(ST_END_IN_ESC);
                DEC_HEX, DEC_LOW_HEX:        raise_error(ST_BAD_HEX);
                DEC_WAIT_BSLASH, DEC_WAIT_U: raise_error(ST_LONE_HIGH);
                default:                     clear_decoder();
            endcase
        end else begin
            case (dec_phase)
                DEC_BODY:   body_byte(c);
                DEC_ESCAPE: escape_letter(c);
                DEC_HEX:    hex_byte(c, 1'b0);
                DEC_WAIT_BSLASH: begin
                    if (c == CH_BSLASH)
                        dec_phase = DEC_WAIT_U;
                    else
                        raise_error(ST_LONE_HIGH);
                end
                DEC_WAIT_U: begin
                    if (c == CH_U) begin
                        dec_phase = DEC_LOW_HEX;
                        hex_acc   = '0;
                        hex_cnt   = '0;
                    end else begin
                        raise_error(ST_LONE_HIGH);
                    end
                end
                DEC_LOW_HEX: hex_byte(c, 1'b1);
                default:     clear_decoder();
            endcase
        end
        if (item_results.size() > 0) begin
            r = item_results[item_results.size() - 1];
            r.last = 1'b1;
            item_results[item_results.size() - 1] = r;
        end
        foreach (item_results[i])
            decoder_results.insert(decoder_results.size(), item_results[i]);
    endfunction

    function automatic void note_mismatch(input string what, input t_result want,
                                          input t_result got);
        string exp_txt;
        string got_txt;
        mismatches++;
        if (mismatches <= 10) begin
            exp_txt = $sformatf("kind=%0d data=%02h status=%0d len=%0d last=%0d",
                                want.kind, want.data, want.status, want.length,
                                want.last);
            got_txt = $sformatf("kind=%0d data=%02h status=%0d len=%0d last=%0d",
                                got.kind, got.data, got.status, got.length,
                                got.last);
            $display("%0t mismatch (%s): expected %s, got %s", $realtime, what,
                     exp_txt, got_txt);
        end
    endfunction

    initial begin
        mismatches = 0;
        max_bytes  = MAX_BYTES_RESET;
        clear_decoder();
    end

    always @(posedge i_clk) begin : watch_ports
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            max_bytes = MAX_BYTES_RESET;
            clear_decoder();
            decoder_results.delete();
        end else begin
            // results leave only after their input has passed the queue and the output register, so check first
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.kind   = i_out_mon.kind;
                got.data   = i_out_mon.data_byte;
                got.status = t_status'(i_out_mon.status);
                got.length = i_out_mon.length;
                got.last   = i_out_mon.last;
                if (decoder_results.size() == 0) begin
                    want = '0;
                    note_mismatch("no result expected", want, got);
                end else begin
                    want = decoder_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.status !== want.status || got.length !== want.length ||
                        got.last !== want.last)
                        note_mismatch("field", want, got);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                decode_item(i_in_mon.mode, i_in_mon.start_req, i_in_mon.in_byte);
            if (i_cfg_mon.valid && i_cfg_mon.ready)
                max_bytes = i_cfg_mon.byte_limit;
        end
        o_mismatches <= mismatches;
        o_pending    <= decoder_results.size();
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of the json string unescaper
// ----------------------------------------------------------------------------
// Drives string bodies into the decoder: a short directed list of corner
// cases, then random strings built from plain bytes, raw utf-8, short and
// unicode escapes and surrogate pairs, with bytes corrupted or cut off now
// and then. The length limit changes between phases while the block is idle.
// Both sides idle at random; jsu_scoreboard predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 26;
    localparam int NUM_PHASES  = 6;

    typedef enum logic [1:0] {
        END_QUOTE,
        END_DOC,
        END_OPEN
    } t_string_end;

    logic i_clk;
    logic i_rst_n;

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();
    jsu_cfg_if cfg_ch ();

    int         mismatches;
    int         pending;
    int         quiet_cycles;
    int         stall_left;
    int         phase_items;
    bit         gaps_on;
    bit         stalls_on;
    logic [7:0] text_bytes[$];

    json_string_unescaper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    jsu_scoreboard chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_mon    (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly short pauses, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (!gaps_on || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    always @(negedge i_clk) begin
        if (!stalls_on || stall_left == 0) begin
            out_ch.ready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 20)
                stall_left <= idle_len();
        end else begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
    end

    // counts cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic mode, input logic start, input logic [7:0] c);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.start_req <= start;
        in_ch.in_byte   <= c;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, i == 0, s[i]);
    endtask

    // wait until every predicted result has come out and the pipe is empty
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [23:0] value);
        @(negedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.byte_limit <= value;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_unicode(input logic [15:0] v);
        add_byte("\\");
        add_byte("u");
        for (int i = 3; i >= 0; i--)
            add_byte(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic logic [7:0] printable();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == "\"" || c == "\\");
        return c;
    endfunction

    function automatic logic [7:0] continuation();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic void push_raw_utf8();
        case ($urandom_range(0, 3))
            0: begin
                add_byte(8'($urandom_range(8'hC2, 8'hDF)));
                add_byte(continuation());
            end
            1: begin
                add_byte(8'($urandom_range(8'hE1, 8'hEC)));
                repeat (2) add_byte(continuation());
            end
            2: begin
                add_byte(8'($urandom_range(8'hF1, 8'hF3)));
                repeat (3) add_byte(continuation());
            end
            default: add_byte(8'($urandom_range(8'h80, 8'hFF)));
        endcase
    endfunction

    function automatic void push_short_escape();
        add_byte("\\");
        case ($urandom_range(0, 7))
            0:       add_byte("b");
            1:       add_byte("f");
            2:       add_byte("n");
            3:       add_byte("r");
            4:       add_byte("t");
            5:       add_byte("\"");
            6:       add_byte("\\");
            default: add_byte("/");
        endcase
    endfunction

    function automatic void push_code_point();
        case ($urandom_range(0, 3))
            0:       push_unicode(16'($urandom_range(16'h0000, 16'h007F)));
            1:       push_unicode(16'($urandom_range(16'h0080, 16'h07FF)));
            2:       push_unicode(16'($urandom_range(16'h0800, 16'hD7FF)));
            default: push_unicode(16'($urandom_range(16'hE000, 16'hFFFF)));
        endcase
    endfunction

    // one string body: mostly well formed, sometimes corrupted or cut short
    task automatic send_random_string();
        int          tokens;
        int          r;
        int          p;
        t_string_end ending;
        text_bytes.delete();
        tokens = $urandom_range(0, 6);
        repeat (tokens) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                add_byte(printable());
            end else if (r < 45) begin
                push_raw_utf8();
            end else if (r < 65) begin
                push_short_escape();
            end else if (r < 83) begin
                push_code_point();
            end else if (r < 97) begin
                push_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else begin
                push_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            add_byte("\"");
            ending = END_QUOTE;
        end else if (r < 85) begin
            ending = END_DOC;
        end else if (r < 92) begin
            ending = END_OPEN;
        end else begin
            add_byte(8'($urandom));
            ending = END_OPEN;
        end
        if (text_bytes.size() > 0 && $urandom_range(0, 99) < 20) begin
            p = $urandom_range(0, text_bytes.size() - 1);
            if ($urandom_range(0, 1)) begin
                text_bytes[p] = 8'($urandom);
            end else begin
                while (text_bytes.size() > p)
                    void'(text_bytes.pop_back());
                ending = END_DOC;
            end
        end
        foreach (text_bytes[i])
            send_item(1'b0, i == 0, text_bytes[i]);
        if (ending == END_DOC || text_bytes.size() == 0)
            send_item(1'b1, text_bytes.size() == 0, 8'($urandom));
        phase_items += text_bytes.size() + ((ending == END_DOC) ? 1 : 0);
        // stray bytes outside a string
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 2))
                send_item(1'($urandom), 1'b0, 8'($urandom));
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = 1'b0;
        in_ch.start_req   = 1'b0;
        in_ch.in_byte     = 8'h00;
        cfg_ch.valid      = 1'b0;
        cfg_ch.byte_limit = 24'h0;
        out_ch.ready      = 1'b0;
        stall_left        = 0;
        quiet_cycles      = 0;
        phase_items       = 0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corner cases at the reset limit
        send_item(1'b0, 1'b0, 8'hFF);
        send_item(1'b1, 1'b1, 8'hA5);
        send_text("\"");
        send_item(1'b0, 1'b1, 8'h1F);
        send_item(1'b0, 1'b1, 8'hFF);
        send_item(1'b0, 1'b0, "\"");
        send_text("\\q");
        send_text("\\");
        send_item(1'b1, 1'b0, 8'h00);
        send_text("\\u0000\\udBfF\\uDFFF\"");

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0:       write_limit(24'h0);
                1:       write_limit(24'hFF_FFFF);
                2:       write_limit(24'($urandom_range(1, 4)));
                3:       write_limit(24'($urandom_range(5, 16)));
                4:       write_limit(24'hFF_FFFE);
                default: write_limit(24'($urandom_range(2, 40)));
            endcase
            // one phase runs at full rate on both sides
            gaps_on     = (ph != 3);
            stalls_on   = (ph != 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_random_string();
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
